FILE: sv/spsu_pkg.sv
// Shared types, codes and phase tables for the stepper phase sequencer.
`default_nettype none

package spsu_pkg;

    // Drive mode codes held in the configuration register.
    typedef enum logic [1:0] {
        MODE_FULL     = 2'd0,
        MODE_HALF     = 2'd1,
        MODE_WAVE     = 2'd2,
        MODE_STEP_DIR = 2'd3
    } mode_t;

    // Pin vector order: bit 0 coil A fwd, bit 1 coil A rev, bit 2 coil B fwd, bit 3 coil B rev.
    typedef logic [3:0] pins_t;

    // One result item as held in the output queue.
    typedef struct packed {
        pins_t pins;
        logic  last;
    } result_t;

    // What the sequencer hands to the output queue for one accepted item.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } push_t;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned PtrW       = $clog2(QueueDepth);
    localparam int unsigned CountW     = PtrW + 1;

    // Full-step coil pattern for each of the four phases.
    function automatic pins_t full_pattern(input logic [1:0] phase);
        pins_t pins;
        begin
            unique case (phase)
                2'd0: pins = 4'd5;
                2'd1: pins = 4'd9;
                2'd2: pins = 4'd10;
                default: pins = 4'd6;
            endcase
            return pins;
        end
    endfunction

    // Half-step coil pattern for each of the eight phases.
    function automatic pins_t half_pattern(input logic [2:0] phase);
        pins_t pins;
        begin
            unique case (phase)
                3'd0: pins = 4'd1;
                3'd1: pins = 4'd5;
                3'd2: pins = 4'd4;
                3'd3: pins = 4'd6;
                3'd4: pins = 4'd2;
                3'd5: pins = 4'd10;
                3'd6: pins = 4'd8;
                default: pins = 4'd9;
            endcase
            return pins;
        end
    endfunction

    // Wave-drive coil pattern: one coil end energised per phase.
    function automatic pins_t wave_pattern(input logic [1:0] phase);
        pins_t pins;
        begin
            unique case (phase)
                2'd0: pins = 4'd1;
                2'd1: pins = 4'd4;
                2'd2: pins = 4'd2;
                default: pins = 4'd8;
            endcase
            return pins;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/spsu_seq.sv
// Phase counters, pin state and drive mode register of the stepper phase sequencer.
`default_nettype none

module spsu_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_wr_en,
    input  wire logic [1:0]      cfg_wr_data,
    input  wire logic            accept,
    input  wire logic            direction,
    output spsu_pkg::push_t      push
);

    spsu_pkg::mode_t mode_reg;
    logic [1:0]      full_phase_reg, full_phase_next;
    logic [2:0]      half_phase_reg, half_phase_next;
    logic [1:0]      wave_phase_reg, wave_phase_next;
    spsu_pkg::pins_t pin_levels_reg, pin_levels_next;
    spsu_pkg::pins_t pulse_high;
    spsu_pkg::pins_t pulse_low;

    // Work out the pins and the counter moves for the item at the input.
    always_comb begin
        full_phase_next = full_phase_reg;
        half_phase_next = half_phase_reg;
        wave_phase_next = wave_phase_reg;
        pulse_high      = {pin_levels_reg[3], 1'b1, pin_levels_reg[1], ~direction};
        pulse_low       = {pin_levels_reg[3], 1'b0, pin_levels_reg[1], ~direction};
        push.two        = 1'b0;
        push.second     = spsu_pkg::result_t'{pins: pulse_low, last: 1'b1};
        unique case (mode_reg)
            spsu_pkg::MODE_FULL: begin
                pin_levels_next = spsu_pkg::full_pattern(full_phase_reg);
                full_phase_next = direction ? full_phase_reg - 2'd1 : full_phase_reg + 2'd1;
            end
            spsu_pkg::MODE_HALF: begin
                pin_levels_next = spsu_pkg::half_pattern(half_phase_reg);
                half_phase_next = direction ? half_phase_reg - 3'd1 : half_phase_reg + 3'd1;
            end
            spsu_pkg::MODE_WAVE: begin
                pin_levels_next = spsu_pkg::wave_pattern(wave_phase_reg);
                wave_phase_next = direction ? wave_phase_reg - 2'd1 : wave_phase_reg + 2'd1;
            end
            default: begin
                pin_levels_next = pulse_low;
                push.two        = 1'b1;
            end
        endcase
        push.first = push.two ? spsu_pkg::result_t'{pins: pulse_high, last: 1'b0}
                              : spsu_pkg::result_t'{pins: pin_levels_next, last: 1'b1};
    end

    // Mode register, written on a configuration write, and per-mode state, moved only when an item is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= spsu_pkg::MODE_FULL;
            full_phase_reg <= '0;
            half_phase_reg <= '0;
            wave_phase_reg <= '0;
            pin_levels_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= spsu_pkg::mode_t'(cfg_wr_data);
            end
            if (accept) begin
                full_phase_reg <= full_phase_next;
                half_phase_reg <= half_phase_next;
                wave_phase_reg <= wave_phase_next;
                pin_levels_reg <= pin_levels_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/spsu_fifo.sv
// Output queue of result items, taking one or two items per push.
`default_nettype none

module spsu_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_en,
    input  wire spsu_pkg::push_t  push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output spsu_pkg::result_t     out_item
);

    spsu_pkg::result_t                  store_reg [spsu_pkg::QueueDepth];
    logic [spsu_pkg::PtrW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [spsu_pkg::PtrW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [spsu_pkg::CountW-1:0]        count_reg, count_next;
    logic [spsu_pkg::CountW-1:0]        push_count;
    logic                               pop;

    // Room for two more items means any item can be taken.
    assign room      = count_reg <= spsu_pkg::CountW'(spsu_pkg::QueueDepth - 2);
    assign out_valid = count_reg != '0;
    assign out_item  = store_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        push_count  = push_en ? (push.two ? spsu_pkg::CountW'(2) : spsu_pkg::CountW'(1)) : '0;
        wr_ptr_next = wr_ptr_reg + push_count[spsu_pkg::PtrW-1:0];
        rd_ptr_next = pop ? rd_ptr_reg + spsu_pkg::PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + push_count - (pop ? spsu_pkg::CountW'(1) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage; a step pulse writes its high and low items together.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            store_reg[wr_ptr_reg] <= push.first;
            if (push.two) begin
                store_reg[wr_ptr_reg + spsu_pkg::PtrW'(1)] <= push.second;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/stepper_phase_sequencer_unit.sv
// Top level of the stepper phase sequencer: step requests in, coil pin items out.
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_direction
// m_        out        m_valid/m_ready    m_coil_a_fwd, m_coil_a_rev, m_coil_b_fwd,
//                                         m_coil_b_rev, m_last
// cfg_      in         cfg_wr_en          cfg_wr_data (drive mode)
//
// A step item is worked out in the cycle it is taken and its results sit in a
// four-entry output queue from the next cycle. Coil modes sustain one item per
// cycle while the output is ready; step/direction mode yields two results per
// item, so the single-read queue port holds back new items there. s_ready is high
// while the queue has room for two items. Reset clears the mode, the phase
// counters, the pin levels and the queue.

module stepper_phase_sequencer_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_direction,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_coil_a_fwd,
    output logic            m_coil_a_rev,
    output logic            m_coil_b_fwd,
    output logic            m_coil_b_rev,
    output logic            m_last
);

    spsu_pkg::push_t   push;
    spsu_pkg::result_t out_item;
    logic              accept;

    assign accept = s_valid && s_ready;

    // Mode register, phase counters and pin state.
    spsu_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .direction   (s_direction),
        .push        (push)
    );

    // Result queue between the sequencer and the output channel.
    spsu_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (accept),
        .push      (push),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (out_item)
    );

    // Unpack the head item onto the pin ports.
    assign m_coil_a_fwd = out_item.pins[0];
    assign m_coil_a_rev = out_item.pins[1];
    assign m_coil_b_fwd = out_item.pins[2];
    assign m_coil_b_rev = out_item.pins[3];
    assign m_last       = out_item.last;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the stepper phase sequencer, with directed and random step items.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Coil patterns per phase, phase 0 in the lowest nibble.
    localparam logic [15:0] FullSeq = {4'd6, 4'd10, 4'd9, 4'd5};
    localparam logic [31:0] HalfSeq = {4'd9, 4'd8, 4'd10, 4'd2, 4'd6, 4'd4, 4'd5, 4'd1};
    localparam logic [15:0] WaveSeq = {4'd8, 4'd2, 4'd4, 4'd1};
    localparam int WatchdogLimit = 2000;
    localparam int MaxReports = 100;
    localparam int RandomPhases = 10;
    localparam int ItemsPerPhase = 123;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_wr_data = 2'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_direction = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_coil_a_fwd;
    logic       m_coil_a_rev;
    logic       m_coil_b_fwd;
    logic       m_coil_b_rev;
    logic       m_last;

    // Step items waiting to be sent and coil items waiting to be seen.
    logic              step_dirs_pending[$];
    spsu_pkg::result_t coil_items_due[$];

    // Own copy of the sequencer state.
    spsu_pkg::mode_t drive_mode = spsu_pkg::MODE_FULL;
    logic [1:0]      full_ph = 2'd0;
    logic [2:0]      half_ph = 3'd0;
    logic [1:0]      wave_ph = 2'd0;
    spsu_pkg::pins_t pin_state = 4'd0;

    int  errors = 0;
    int  steps_sent = 0;
    int  coils_checked = 0;
    int  mode_writes = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;

    stepper_phase_sequencer_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_direction  (s_direction),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coil_a_fwd (m_coil_a_fwd),
        .m_coil_a_rev (m_coil_a_rev),
        .m_coil_b_fwd (m_coil_b_fwd),
        .m_coil_b_rev (m_coil_b_rev),
        .m_last       (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Work out the coil items that one step item causes and queue them.
    task automatic predict_coil_items(input logic rev);
        spsu_pkg::result_t item;
        case (drive_mode)
            spsu_pkg::MODE_FULL: begin
                pin_state = FullSeq[{full_ph, 2'b00} +: 4];
                full_ph = rev ? full_ph - 2'd1 : full_ph + 2'd1;
            end
            spsu_pkg::MODE_HALF: begin
                pin_state = HalfSeq[{half_ph, 2'b00} +: 4];
                half_ph = rev ? half_ph - 3'd1 : half_ph + 3'd1;
            end
            spsu_pkg::MODE_WAVE: begin
                pin_state = WaveSeq[{wave_ph, 2'b00} +: 4];
                wave_ph = rev ? wave_ph - 2'd1 : wave_ph + 2'd1;
            end
            default: begin
                // Direction pin set from rev and step pulse high; the inverted pins keep their levels.
                pin_state = {pin_state[3], 1'b1, pin_state[1], ~rev};
                item.pins = pin_state;
                item.last = 1'b0;
                coil_items_due.push_back(item);
                pin_state[2] = 1'b0;
            end
        endcase
        item.pins = pin_state;
        item.last = 1'b1;
        coil_items_due.push_back(item);
    endtask

    task automatic report_field(input string field, input logic want, input logic got);
        if (want !== got) begin
            errors++;
            if (errors <= MaxReports) begin
                $display("%0t: %s mismatch, expected %0b, actual %0b", $realtime, field, want,
                         got);
            end
        end
    endtask

    // Sender: offers queued step items, with random bursts of idle cycles.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_direction <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_coil_items(s_direction);
                steps_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (step_dirs_pending.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 17) - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_direction <= step_dirs_pending.pop_front();
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver: checks each coil item against the oldest expectation, stalls in bursts.
    always @(posedge aclk) begin
        spsu_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                coils_checked++;
                if (coil_items_due.size() == 0) begin
                    errors++;
                    if (errors <= MaxReports) begin
                        $display("%0t: unexpected coil item, expected nothing, actual %b last %b",
                                 $realtime, {m_coil_b_rev, m_coil_b_fwd, m_coil_a_rev,
                                 m_coil_a_fwd}, m_last);
                    end
                end else begin
                    want = coil_items_due.pop_front();
                    report_field("coil_a_fwd", want.pins[0], m_coil_a_fwd);
                    report_field("coil_a_rev", want.pins[1], m_coil_a_rev);
                    report_field("coil_b_fwd", want.pins[2], m_coil_b_fwd);
                    report_field("coil_b_rev", want.pins[3], m_coil_b_rev);
                    report_field("last", want.last, m_last);
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_stall = $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchdogLimit) begin
                    $display("Timeout after %0d cycles with no item moving.", quiet_cycles);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    task automatic queue_run(input logic rev, input int count);
        repeat (count) step_dirs_pending.push_back(rev);
    endtask

    // Wait until every step item is sent and every coil item has come back.
    task automatic wait_drained();
        while (step_dirs_pending.size() != 0 || s_valid || coil_items_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_drive_mode(input spsu_pkg::mode_t mode);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        drive_mode = mode;
        mode_writes++;
    endtask

    initial begin
        int remaining;
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset mode is full step: walk forward round the wrap, then back past phase zero.
        queue_run(1'b0, 5);
        queue_run(1'b1, 3);
        wait_drained();

        // Half step: reverse wrap from zero, then forward wrap back.
        set_drive_mode(spsu_pkg::MODE_HALF);
        queue_run(1'b1, 2);
        queue_run(1'b0, 3);
        wait_drained();

        // Wave drive, leaving an inverted pin high for the next mode.
        set_drive_mode(spsu_pkg::MODE_WAVE);
        queue_run(1'b1, 2);
        queue_run(1'b0, 2);
        wait_drained();

        // Step/direction: both directions, inverted pins must keep their levels.
        set_drive_mode(spsu_pkg::MODE_STEP_DIR);
        queue_run(1'b0, 1);
        queue_run(1'b1, 1);
        queue_run(1'b0, 1);
        wait_drained();

        // Back to full step: its counter must have held its place.
        set_drive_mode(spsu_pkg::MODE_FULL);
        queue_run(1'b0, 2);
        wait_drained();

        // Random phases, each under one mode, with direction runs to sweep the counters.
        for (int p = 0; p < RandomPhases; p++) begin
            if (p < 8) begin
                set_drive_mode(spsu_pkg::mode_t'((p * 3 + 1) % 4));
            end else begin
                set_drive_mode(spsu_pkg::mode_t'($urandom_range(0, 3)));
            end
            if (p == RandomPhases - 1) begin
                calm = 1'b1;
            end
            remaining = ItemsPerPhase;
            while (remaining > 0) begin
                len = $urandom_range(1, 12);
                if (len > remaining) begin
                    len = remaining;
                end
                queue_run(1'($urandom_range(0, 1)), len);
                remaining -= len;
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("Sent %0d step items under %0d drive mode writes; checked %0d coil items.",
                 steps_sent, mode_writes, coils_checked);
        $display("Mismatches found: %0d.", errors);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/spsu_pkg.sv
sv/spsu_seq.sv
sv/spsu_fifo.sv
sv/stepper_phase_sequencer_unit.sv
dv/tb_top.sv
